// ----- src/fla_pkg.sv -----
// Package for the free-list cell allocator: widths, action and status codes,
// and the command/status structs between controller and datapath. No dependencies.
package fla_pkg;

  localparam int POOL_DEPTH = 1024;
  localparam int IDX_W      = $clog2(POOL_DEPTH);
  localparam int PTR_W      = IDX_W + 1;
  localparam int ACT_W      = 2;
  localparam int STS_W      = 2;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [ACT_W-1:0] act_t;
  typedef logic [STS_W-1:0] sts_t;

  // head value meaning "list empty"
  localparam ptr_t NONE_MARK = ptr_t'(POOL_DEPTH);

  localparam act_t ACT_ALLOC = 2'd0;
  localparam act_t ACT_FREE  = 2'd1;
  localparam act_t ACT_INIT  = 2'd2;

  localparam sts_t STS_OK        = 2'd0;
  localparam sts_t STS_EMPTY     = 2'd1;
  localparam sts_t STS_NULL_FREE = 2'd2;

  typedef struct packed {
    logic in_ready;
    logic accept;       // latch input transaction, read link of head
    logic exec;         // alloc / free / unused code: update head, load result
    logic init_start;   // clear head, reset sweep counter
    logic init_push;    // link one more cell during rebuild
    logic init_finish;  // load result of init
  } fla_cmd_t;

  typedef struct packed {
    logic op_init;
    logic init_done;
    logic out_free;
  } fla_sts_t;

endpackage

// ----- src/fla_in_if.sv -----
// Input channel of the free-list allocator: valid/ready plus request fields.
// Depends on fla_pkg.
interface fla_in_if;
  import fla_pkg::*;

  logic valid;
  logic ready;
  act_t action;
  idx_t cell_index;
  logic cell_is_null;

  modport source (output valid, action, cell_index, cell_is_null, input ready);
  modport sink   (input valid, action, cell_index, cell_is_null, output ready);
endinterface

// ----- src/fla_out_if.sv -----
// Result channel of the free-list allocator: valid/ready plus result fields.
// Depends on fla_pkg.
interface fla_out_if;
  import fla_pkg::*;

  logic valid;
  logic ready;
  idx_t given_index;
  sts_t status;
  logic pool_empty;

  modport source (output valid, given_index, status, pool_empty, input ready);
  modport sink   (input valid, given_index, status, pool_empty, output ready);
endinterface

// ----- src/fla_ctrl.sv -----
// Controller state machine of the free-list allocator.
// Depends on fla_pkg; drives commands into fla_dp.
module fla_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  fla_pkg::fla_sts_t sts,
  output fla_pkg::fla_cmd_t cmd
);
  import fla_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_INIT = 2'd2;

  logic [1:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.op_init) begin
          cmd.init_start = 1'b1;
          state_nxt      = S_INIT;
        end else if (sts.out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_INIT: begin
        if (!sts.init_done) begin
          cmd.init_push = 1'b1;
        end else if (sts.out_free) begin
          cmd.init_finish = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ----- src/fla_dp.sv -----
// Datapath of the free-list allocator: link memory, head register, init sweep
// counter, pool_count register and result register. Depends on fla_pkg.
module fla_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  fla_pkg::fla_cmd_t cmd,
  output fla_pkg::fla_sts_t sts,
  input  logic              cfg_we,
  input  fla_pkg::ptr_t     cfg_data,
  input  fla_pkg::act_t     in_action,
  input  fla_pkg::idx_t     in_cell_index,
  input  logic              in_cell_is_null,
  output logic              out_valid,
  input  logic              out_ready,
  output fla_pkg::idx_t     out_given_index,
  output fla_pkg::sts_t     out_status,
  output logic              out_pool_empty
);
  import fla_pkg::*;

  ptr_t link_mem [POOL_DEPTH];
  ptr_t link_rd_r;

  ptr_t head_r, head_nxt;
  ptr_t cnt_r, cnt_nxt;
  ptr_t pool_count_r;
  ptr_t pool_n;

  act_t act_r;
  idx_t cell_r;
  logic null_r;

  logic out_valid_r, out_valid_nxt;
  idx_t given_r, given_nxt;
  sts_t status_r, status_nxt;
  logic empty_r;

  logic mem_we;
  idx_t mem_waddr;
  logic load_out;

  assign pool_n = (pool_count_r > NONE_MARK) ? NONE_MARK : pool_count_r;

  assign sts.op_init   = (act_r == ACT_INIT);
  assign sts.init_done = (cnt_r == pool_n);
  assign sts.out_free  = !out_valid_r || out_ready;

  assign load_out = cmd.exec || cmd.init_finish;

  always_comb begin
    head_nxt   = head_r;
    cnt_nxt    = cnt_r;
    given_nxt  = '0;
    status_nxt = STS_OK;
    mem_we     = 1'b0;
    mem_waddr  = cell_r;
    if (cmd.exec) begin
      case (act_r)
        ACT_ALLOC: begin
          if (head_r[PTR_W-1]) begin
            status_nxt = STS_EMPTY;
          end else begin
            given_nxt = head_r[IDX_W-1:0];
            head_nxt  = link_rd_r;
          end
        end
        ACT_FREE: begin
          if (null_r) begin
            status_nxt = STS_NULL_FREE;
          end else begin
            mem_we   = 1'b1;
            head_nxt = {1'b0, cell_r};
          end
        end
        default: begin
        end
      endcase
    end
    if (cmd.init_start) begin
      head_nxt = NONE_MARK;
      cnt_nxt  = '0;
    end
    // rebuild pushes cells 0..n-1 in order, same as a free of each
    if (cmd.init_push) begin
      mem_we    = 1'b1;
      mem_waddr = cnt_r[IDX_W-1:0];
      head_nxt  = cnt_r;
      cnt_nxt   = cnt_r + 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r       <= NONE_MARK;
      cnt_r        <= '0;
      pool_count_r <= NONE_MARK;
      out_valid_r  <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        pool_count_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act_r  <= in_action;
      cell_r <= in_cell_index;
      null_r <= in_cell_is_null;
    end
    if (load_out) begin
      given_r  <= given_nxt;
      status_r <= status_nxt;
      empty_r  <= head_nxt[PTR_W-1];
    end
  end

  // link memory: one write port, one registered read of the head's link
  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= head_r;
    end
    if (cmd.accept) begin
      link_rd_r <= link_mem[head_r[IDX_W-1:0]];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_given_index = given_r;
  assign out_status      = status_r;
  assign out_pool_empty  = empty_r;

endmodule

// ----- src/free_list_cell_allocator_top.sv -----
// Free-list cell allocator, top level. Depends on fla_pkg, fla_in_if, fla_out_if,
// fla_ctrl and fla_dp.
//
// Hands out and takes back cell indices of a 1024-cell pool kept as a linked
// free list in a single-port-write link memory with a head register. One
// request is worked at a time. For alloc, free and unused codes the accept
// cycle issues the synchronous read of the head cell's link, and the S_EXEC
// state updates the head and loads the result once the result register is
// free. Init rebuilds the list by writing one link per cycle for min(pool_count,
// 1024) cells. The result register lets a new request be accepted while the
// previous result is still waiting on out_ch.ready. pool_count is written
// via cfg_we/cfg_data by the user only while idle; the block does not enforce it.
module free_list_cell_allocator_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  fla_pkg::ptr_t cfg_data,
  fla_in_if.sink        in_ch,
  fla_out_if.source     out_ch
);
  import fla_pkg::*;

  fla_cmd_t cmd;
  fla_sts_t sts;

  assign in_ch.ready = cmd.in_ready;

  fla_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .sts      (sts),
    .cmd      (cmd)
  );

  fla_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .in_action       (in_ch.action),
    .in_cell_index   (in_ch.cell_index),
    .in_cell_is_null (in_ch.cell_is_null),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_given_index (out_ch.given_index),
    .out_status      (out_ch.status),
    .out_pool_empty  (out_ch.pool_empty)
  );

endmodule
